@@ rtl/snx_pkg.sv @@
// ----------------------------------------------------------------------------
// snx_pkg: shared types and constants for the simplex noise accumulator
// Fixed-point constants (Q16.16), action and register codes, item tag and
// the gradient lookup used by the corner stages.
// ----------------------------------------------------------------------------
package snx_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 16;
  localparam int NSTAGE     = 15;
  localparam int NCORNER    = 4;
  localparam int OFS_W      = 26;

  // Skew and unskew factors, Q16.16
  localparam logic signed [17:0] F2   = 18'sd23988;
  localparam logic signed [17:0] G2   = 18'sd13849;
  localparam logic signed [17:0] F3   = 18'sd21845;
  localparam logic signed [17:0] G3   = 18'sd10923;
  localparam logic signed [17:0] LIM2 = 18'sd32768;
  localparam logic signed [17:0] LIM3 = 18'sd39322;
  localparam logic signed [OFS_W-1:0] ONE = 26'sd65536;
  localparam logic signed [17:0] NOISE_MAX = 18'sd65536;
  localparam logic signed [17:0] NOISE_MIN = -18'sd65536;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_NOISE2 = 2'd1,
    ACT_NOISE3 = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_SCALE_X   = 3'd3,
    REG_SCALE_Y   = 3'd4,
    REG_SCALE_Z   = 3'd5,
    REG_AMPLITUDE = 3'd6
  } reg_idx_t;

  // Tag that travels with every word down the pipeline
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] acc_in;
    logic [7:0]         tbl_idx;
    logic [7:0]         tbl_val;
  } item_meta_t;

  // Gradient direction: per axis an enable and a sign
  typedef struct packed {
    logic x_on;
    logic x_neg;
    logic y_on;
    logic y_neg;
    logic z_on;
    logic z_neg;
  } grad_t;

  function automatic logic is_noise(input logic [1:0] act);
    is_noise = (act == ACT_NOISE2) || (act == ACT_NOISE3);
  endfunction

  // Reduce a table byte mod 12 (reciprocal multiply) and pick its gradient
  function automatic grad_t grad_of(input logic [7:0] v);
    logic [18:0] pq;
    logic [7:0]  q;
    logic [7:0]  r;
    grad_t       g;
    pq = {11'b0, v} * 19'd171;
    q  = 8'(pq >> 11);
    r  = v - 8'({q, 3'b0} + {1'b0, q, 2'b0});
    unique case (r[3:0])
      4'd0:    g = 6'b10_10_00;
      4'd1:    g = 6'b11_10_00;
      4'd2:    g = 6'b10_11_00;
      4'd3:    g = 6'b11_11_00;
      4'd4:    g = 6'b10_00_10;
      4'd5:    g = 6'b11_00_10;
      4'd6:    g = 6'b10_00_11;
      4'd7:    g = 6'b11_00_11;
      4'd8:    g = 6'b00_10_10;
      4'd9:    g = 6'b00_11_10;
      4'd10:   g = 6'b00_10_11;
      4'd11:   g = 6'b00_11_11;
      default: g = '0;
    endcase
    grad_of = g;
  endfunction

endpackage

@@ rtl/simplex_noise_accumulate.sv @@
// ----------------------------------------------------------------------------
// simplex_noise_accumulate: 2D/3D simplex noise added into a sample
// Fifteen-stage pipeline with replicated permutation tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item: action,
//   position, acc_in and a table entry. A load word writes one table byte and
//   gives no result; a 2D or 3D noise word gives one output word
//   (acc_out, noise_value) on out_valid/out_ready. Unused action code 3 is
//   dropped.
//   One word per cycle is accepted in steady state while the output is not
//   stalled. The depth is set by the three chained table reads, each a
//   registered read of its own set of table copies, and the four multiplies
//   of the falloff term.
//   Each stage advances when the next one is empty or moving, so bubbles are
//   squeezed out and words keep flowing while a result waits at the output.
//   When the receiver stalls with every stage full, in_ready drops; nothing
//   is lost or repeated.
//   Registers sit on an APB port at byte address 4*index; the user must make
//   writes while the block is idle, which the block does not enforce. Reset
//   clears the pipeline and loads register defaults; the table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module simplex_noise_accumulate (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] acc_in,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] acc_out,
  output logic signed [17:0] noise_value
);

  import snx_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] origin_x, origin_y, origin_z;
  logic [31:0] scale_x, scale_y, scale_z;
  logic [23:0] amplitude;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      scale_x   <= 32'd65536;
      scale_y   <= 32'd65536;
      scale_z   <= 32'd65536;
      amplitude <= 24'd65536;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_ORIGIN_X:  origin_x  <= pwdata[23:0];
        REG_ORIGIN_Y:  origin_y  <= pwdata[23:0];
        REG_ORIGIN_Z:  origin_z  <= pwdata[23:0];
        REG_SCALE_X:   scale_x   <= pwdata;
        REG_SCALE_Y:   scale_y   <= pwdata;
        REG_SCALE_Z:   scale_z   <= pwdata;
        REG_AMPLITUDE: amplitude <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_ORIGIN_X:  prdata = {8'b0, origin_x};
      REG_ORIGIN_Y:  prdata = {8'b0, origin_y};
      REG_ORIGIN_Z:  prdata = {8'b0, origin_z};
      REG_SCALE_X:   prdata = scale_x;
      REG_SCALE_Y:   prdata = scale_y;
      REG_SCALE_Z:   prdata = scale_z;
      REG_AMPLITUDE: prdata = {8'b0, amplitude};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: valid and tag per stage, advance when next can take
  // --------------------------------------------------------------------------
  logic       vld  [1:NSTAGE];
  item_meta_t meta [1:NSTAGE];
  logic       go   [1:NSTAGE];

  always_comb begin
    go[NSTAGE] = !vld[NSTAGE] || !is_noise(meta[NSTAGE].action) || out_ready;
    for (int s = NSTAGE - 1; s >= 1; s--) begin
      go[s] = !vld[s] || go[s+1];
    end
  end

  assign in_ready  = go[1];
  assign out_valid = vld[NSTAGE] && is_noise(meta[NSTAGE].action);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NSTAGE; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      if (go[1]) begin
        vld[1] <= in_valid;
      end
      for (int s = 2; s <= NSTAGE; s++) begin
        if (go[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      meta[1] <= '{action, acc_in, table_index, table_value};
    end
    for (int s = 2; s <= NSTAGE; s++) begin
      if (go[s]) begin
        meta[s] <= meta[s-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture position
  // --------------------------------------------------------------------------
  logic signed [31:0] s1_px, s1_py, s1_pz;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s1_px <= pos_x;
      s1_py <= pos_y;
      s1_pz <= pos_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: position times scale
  // --------------------------------------------------------------------------
  logic signed [63:0] s2_mx, s2_my, s2_mz;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s2_mx <= s1_px * $signed({1'b0, scale_x});
      s2_my <= s1_py * $signed({1'b0, scale_y});
      s2_mz <= s1_pz * $signed({1'b0, scale_z});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: add origin, saturate to 32 bits
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] sat_coord(input logic signed [63:0] p,
                                                    input logic [23:0] org);
    logic signed [48:0] c;
    c = $signed({p[63], p[63:16]}) + $signed({25'b0, org});
    if (c > 49'sd2147483647) begin
      sat_coord = $signed(32'h7fffffff);
    end else if (c < -49'sd2147483648) begin
      sat_coord = $signed(32'h80000000);
    end else begin
      sat_coord = c[31:0];
    end
  endfunction

  logic signed [31:0] s3_x, s3_y, s3_z;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s3_x <= sat_coord(s2_mx, origin_x);
      s3_y <= sat_coord(s2_my, origin_y);
      s3_z <= sat_coord(s2_mz, origin_z);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: skew product (x+y[+z]) * F
  // --------------------------------------------------------------------------
  logic signed [33:0] sum4;
  logic signed [51:0] prod4;
  logic signed [51:0] s4_prod;
  logic signed [31:0] s4_x, s4_y, s4_z;

  always_comb begin
    if (meta[3].action == ACT_NOISE3) begin
      sum4  = s3_x + s3_y + s3_z;
      prod4 = sum4 * F3;
    end else begin
      sum4  = s3_x + s3_y;
      prod4 = sum4 * F2;
    end
  end

  always_ff @(posedge clk) begin
    if (go[4]) begin
      s4_prod <= prod4;
      s4_x    <= s3_x;
      s4_y    <= s3_y;
      s4_z    <= s3_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: cell index i = floor(x + s)
  // --------------------------------------------------------------------------
  logic signed [35:0] sk5;
  logic signed [37:0] ux, uy, uz;
  logic signed [21:0] s5_i, s5_j, s5_k;
  logic signed [31:0] s5_x, s5_y, s5_z;

  always_comb begin
    sk5 = s4_prod[51:16];
    ux  = s4_x + sk5;
    uy  = s4_y + sk5;
    uz  = s4_z + sk5;
  end

  always_ff @(posedge clk) begin
    if (go[5]) begin
      s5_i <= ux[37:16];
      s5_j <= uy[37:16];
      s5_k <= uz[37:16];
      s5_x <= s4_x;
      s5_y <= s4_y;
      s5_z <= s4_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: unskew t = (i+j[+k]) * G
  // --------------------------------------------------------------------------
  logic signed [23:0] sumi6;
  logic signed [41:0] t6;
  logic signed [41:0] s6_t;
  logic signed [21:0] s6_i, s6_j, s6_k;
  logic signed [31:0] s6_x, s6_y, s6_z;

  always_comb begin
    if (meta[5].action == ACT_NOISE3) begin
      sumi6 = s5_i + s5_j + s5_k;
      t6    = sumi6 * G3;
    end else begin
      sumi6 = s5_i + s5_j;
      t6    = sumi6 * G2;
    end
  end

  always_ff @(posedge clk) begin
    if (go[6]) begin
      s6_t <= t6;
      s6_i <= s5_i;
      s6_j <= s5_j;
      s6_k <= s5_k;
      s6_x <= s5_x;
      s6_y <= s5_y;
      s6_z <= s5_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: first corner offset x0 = x - i*ONE + t
  // --------------------------------------------------------------------------
  logic signed [43:0] wx, wy, wz;
  logic signed [OFS_W-1:0] s7_x0, s7_y0, s7_z0;
  logic [7:0] s7_ii, s7_jj, s7_kk;

  always_comb begin
    wx = s6_x - $signed({s6_i, 16'b0}) + s6_t;
    wy = s6_y - $signed({s6_j, 16'b0}) + s6_t;
    wz = s6_z - $signed({s6_k, 16'b0}) + s6_t;
  end

  always_ff @(posedge clk) begin
    if (go[7]) begin
      s7_x0 <= wx[OFS_W-1:0];
      s7_y0 <= wy[OFS_W-1:0];
      s7_z0 <= (meta[6].action == ACT_NOISE3) ? wz[OFS_W-1:0] : '0;
      s7_ii <= s6_i[7:0];
      s7_jj <= s6_j[7:0];
      s7_kk <= s6_k[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: order corners, form all corner offsets
  // --------------------------------------------------------------------------
  logic [2:0]              ofs8 [NCORNER];
  logic signed [17:0]      cst8 [NCORNER];
  logic signed [OFS_W-1:0] d8   [NCORNER][3];
  logic                    en8  [NCORNER];
  logic                    three8;
  logic                    ax8;
  logic [2:0]              oa8, ob8;
  logic signed [17:0]      gsel8;

  logic signed [OFS_W-1:0] s8_d   [NCORNER][3];
  logic [2:0]              s8_o   [NCORNER];
  logic                    s8_en  [NCORNER];
  logic [7:0]              s8_ii, s8_jj, s8_kk;

  always_comb begin
    three8 = (meta[7].action == ACT_NOISE3);
    ax8    = (s7_x0 > s7_y0);
    gsel8  = three8 ? G3 : G2;
    // bit 0: x, bit 1: y, bit 2: z
    if (s7_x0 >= s7_y0) begin
      if (s7_y0 >= s7_z0) begin
        oa8 = 3'b001;
        ob8 = 3'b011;
      end else if (s7_x0 >= s7_z0) begin
        oa8 = 3'b001;
        ob8 = 3'b101;
      end else begin
        oa8 = 3'b100;
        ob8 = 3'b101;
      end
    end else begin
      if (s7_y0 < s7_z0) begin
        oa8 = 3'b100;
        ob8 = 3'b110;
      end else if (s7_x0 < s7_z0) begin
        oa8 = 3'b010;
        ob8 = 3'b110;
      end else begin
        oa8 = 3'b010;
        ob8 = 3'b011;
      end
    end
    ofs8[0] = 3'b000;
    ofs8[1] = three8 ? oa8 : {1'b0, !ax8, ax8};
    ofs8[2] = three8 ? ob8 : 3'b011;
    ofs8[3] = 3'b111;
    en8[0]  = 1'b1;
    en8[1]  = 1'b1;
    en8[2]  = 1'b1;
    en8[3]  = three8;
    cst8[0] = '0;
    cst8[1] = gsel8;
    cst8[2] = gsel8 + gsel8;
    cst8[3] = gsel8 + gsel8 + gsel8;
    for (int c = 0; c < NCORNER; c++) begin
      d8[c][0] = s7_x0 - (ofs8[c][0] ? ONE : 26'sd0) + cst8[c];
      d8[c][1] = s7_y0 - (ofs8[c][1] ? ONE : 26'sd0) + cst8[c];
      d8[c][2] = three8 ? (s7_z0 - (ofs8[c][2] ? ONE : 26'sd0) + cst8[c]) : 26'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (go[8]) begin
      for (int c = 0; c < NCORNER; c++) begin
        for (int a = 0; a < 3; a++) begin
          s8_d[c][a] <= d8[c][a];
        end
        s8_o[c]  <= ofs8[c];
        s8_en[c] <= en8[c];
      end
      s8_ii <= s7_ii;
      s8_jj <= s7_jj;
      s8_kk <= s7_kk;
    end
  end

  // --------------------------------------------------------------------------
  // Permutation table copies: one per corner and hash level, each written as
  // a load word passes the stage that reads it, so order is kept
  // --------------------------------------------------------------------------
  logic       tbl_wr    [3];
  logic [7:0] tbl_waddr [3];
  logic [7:0] tbl_wdata [3];
  logic       tbl_rd    [3];
  logic [7:0] tbl_raddr [3][NCORNER];
  logic [7:0] tbl_rdata [3][NCORNER];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      tbl_wr[l]    = go[9+l] && vld[8+l] && (meta[8+l].action == ACT_LOAD);
      tbl_waddr[l] = meta[8+l].tbl_idx;
      tbl_wdata[l] = meta[8+l].tbl_val;
      tbl_rd[l]    = go[9+l];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lvl
    for (genvar c = 0; c < NCORNER; c++) begin : g_crn
      snx_perm_ram #(
        .DEPTH (TABLE_SIZE),
        .WIDTH (8)
      ) u_ram (
        .clk     (clk),
        .wr_en   (tbl_wr[l]),
        .wr_addr (tbl_waddr[l]),
        .wr_data (tbl_wdata[l]),
        .rd_en   (tbl_rd[l]),
        .rd_addr (tbl_raddr[l][c]),
        .rd_data (tbl_rdata[l][c])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: first hash level (k), squared offsets
  // --------------------------------------------------------------------------
  logic signed [51:0]      sqp9 [NCORNER][3];
  logic [33:0]             s9_sq [NCORNER][3];
  logic [1:0]              s9_o  [NCORNER];
  logic                    s9_en [NCORNER];
  logic [7:0]              s9_ii, s9_jj;
  logic signed [OFS_W-1:0] s9_d  [NCORNER][3];

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      tbl_raddr[0][c] = s8_kk + {7'b0, s8_o[c][2]};
      for (int a = 0; a < 3; a++) begin
        sqp9[c][a] = s8_d[c][a] * s8_d[c][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[9]) begin
      for (int c = 0; c < NCORNER; c++) begin
        for (int a = 0; a < 3; a++) begin
          s9_sq[c][a] <= sqp9[c][a][49:16];
          s9_d[c][a]  <= s8_d[c][a];
        end
        s9_o[c]  <= s8_o[c][1:0];
        s9_en[c] <= s8_en[c];
      end
      s9_ii <= s8_ii;
      s9_jj <= s8_jj;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: second hash level (j), falloff t = lim - |d|^2
  // --------------------------------------------------------------------------
  logic signed [36:0]      tsum10 [NCORNER];
  logic signed [17:0]      lim10;
  logic [15:0]             s10_tt   [NCORNER];
  logic                    s10_live [NCORNER];
  logic                    s10_oi   [NCORNER];
  logic [7:0]              s10_ii;
  logic signed [OFS_W-1:0] s10_d    [NCORNER][3];

  always_comb begin
    lim10 = (meta[9].action == ACT_NOISE3) ? LIM3 : LIM2;
    for (int c = 0; c < NCORNER; c++) begin
      tbl_raddr[1][c] = s9_jj + {7'b0, s9_o[c][1]}
                      + ((meta[9].action == ACT_NOISE3) ? tbl_rdata[0][c] : 8'd0);
      tsum10[c] = lim10 - $signed({1'b0, s9_sq[c][0]})
                        - $signed({1'b0, s9_sq[c][1]})
                        - $signed({1'b0, s9_sq[c][2]});
    end
  end

  always_ff @(posedge clk) begin
    if (go[10]) begin
      for (int c = 0; c < NCORNER; c++) begin
        s10_tt[c]   <= tsum10[c][15:0];
        s10_live[c] <= s9_en[c] && !tsum10[c][36];
        s10_oi[c]   <= s9_o[c][0];
        for (int a = 0; a < 3; a++) begin
          s10_d[c][a] <= s9_d[c][a];
        end
      end
      s10_ii <= s9_ii;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: third hash level (i), t^2
  // --------------------------------------------------------------------------
  logic [31:0]             t2p11 [NCORNER];
  logic [15:0]             s11_t2   [NCORNER];
  logic                    s11_live [NCORNER];
  logic signed [OFS_W-1:0] s11_d    [NCORNER][3];

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      tbl_raddr[2][c] = s10_ii + {7'b0, s10_oi[c]} + tbl_rdata[1][c];
      t2p11[c]        = s10_tt[c] * s10_tt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (go[11]) begin
      for (int c = 0; c < NCORNER; c++) begin
        s11_t2[c]   <= t2p11[c][31:16];
        s11_live[c] <= s10_live[c];
        for (int a = 0; a < 3; a++) begin
          s11_d[c][a] <= s10_d[c][a];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: gradient dot product, t^4
  // --------------------------------------------------------------------------
  grad_t              gr12  [NCORNER];
  logic signed [27:0] dot12 [NCORNER];
  logic [31:0]        t4p12 [NCORNER];
  logic signed [27:0] s12_dot  [NCORNER];
  logic [15:0]        s12_t4   [NCORNER];
  logic               s12_live [NCORNER];

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      gr12[c]  = grad_of(tbl_rdata[2][c]);
      dot12[c] = (gr12[c].x_on ? (gr12[c].x_neg ? -s11_d[c][0] : s11_d[c][0]) : 28'sd0)
               + (gr12[c].y_on ? (gr12[c].y_neg ? -s11_d[c][1] : s11_d[c][1]) : 28'sd0)
               + (gr12[c].z_on ? (gr12[c].z_neg ? -s11_d[c][2] : s11_d[c][2]) : 28'sd0);
      t4p12[c] = s11_t2[c] * s11_t2[c];
    end
  end

  always_ff @(posedge clk) begin
    if (go[12]) begin
      for (int c = 0; c < NCORNER; c++) begin
        s12_dot[c]  <= dot12[c];
        s12_t4[c]   <= t4p12[c][31:16];
        s12_live[c] <= s11_live[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13: corner contribution t^4 * dot
  // --------------------------------------------------------------------------
  logic signed [44:0] cp13 [NCORNER];
  logic signed [28:0] s13_c [NCORNER];

  always_comb begin
    for (int c = 0; c < NCORNER; c++) begin
      cp13[c] = $signed({1'b0, s12_t4[c]}) * s12_dot[c];
    end
  end

  always_ff @(posedge clk) begin
    if (go[13]) begin
      for (int c = 0; c < NCORNER; c++) begin
        s13_c[c] <= s12_live[c] ? cp13[c][44:16] : 29'sd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 14: sum corners, scale by 70 or 32, clamp to [-1, 1]
  // --------------------------------------------------------------------------
  logic signed [30:0] sum14;
  logic signed [37:0] nraw14;
  logic signed [17:0] s14_n;

  always_comb begin
    sum14 = s13_c[0] + s13_c[1] + s13_c[2] + s13_c[3];
    if (meta[13].action == ACT_NOISE3) begin
      nraw14 = sum14 <<< 5;
    end else begin
      nraw14 = (sum14 <<< 6) + (sum14 <<< 2) + (sum14 <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (go[14]) begin
      if (nraw14 > NOISE_MAX) begin
        s14_n <= NOISE_MAX;
      end else if (nraw14 < NOISE_MIN) begin
        s14_n <= NOISE_MIN;
      end else begin
        s14_n <= nraw14[17:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 15: weight by amplitude, accumulate, saturate; output word
  // --------------------------------------------------------------------------
  logic signed [42:0] wp15;
  logic signed [32:0] acc15;

  always_comb begin
    wp15  = s14_n * $signed({1'b0, amplitude});
    acc15 = $signed(meta[14].acc_in) + $signed(wp15[42:16]);
  end

  always_ff @(posedge clk) begin
    if (go[15]) begin
      noise_value <= s14_n;
      if (acc15 > 33'sd2147483647) begin
        acc_out <= $signed(32'h7fffffff);
      end else if (acc15 < -33'sd2147483648) begin
        acc_out <= $signed(32'h80000000);
      end else begin
        acc_out <= acc15[31:0];
      end
    end
  end

`ifndef SYNTHESIS
  // Input backs up only when the whole pipe is full and the output stalls
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low while output not stalled");

  // Load words never surface as results
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (vld[NSTAGE] && (meta[NSTAGE].action == ACT_LOAD)) |-> !out_valid)
    else $error("load word produced a result");

  // Noise stays within [-1, 1]
  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((noise_value <= NOISE_MAX) && (noise_value >= NOISE_MIN)))
    else $error("noise out of range");

  // Zero noise leaves the accumulator unchanged
  a_zero_passes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (noise_value == 18'sd0)) |-> (acc_out == meta[NSTAGE].acc_in))
    else $error("accumulator changed by zero noise");
`endif

endmodule

@@ rtl/snx_perm_ram.sv @@
// ----------------------------------------------------------------------------
// snx_perm_ram: one copy of the permutation table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module snx_perm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word, hold it while the stage stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Simplex noise accumulator testbench
// Loads a shuffled permutation table, then sends directed and random 2D/3D
// noise words, loads and dropped words through several register settings and
// idle patterns. Every output word is checked against an in-order prediction.
// ----------------------------------------------------------------------------
module testbench;
  import snx_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT = 4000;
  localparam longint ONE_Q = 65536;
  localparam longint SKEW2 = 23988;
  localparam longint UNSKEW2 = 13849;
  localparam longint SKEW3 = 21845;
  localparam longint UNSKEW3 = 10923;
  localparam longint FALL2 = 32768;
  localparam longint FALL3 = 39322;

  typedef struct {
    logic signed [31:0] acc;
    logic signed [17:0] noise;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ACT_LOAD;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, acc_in = '0;
  logic [7:0] table_index = '0, table_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] acc_out;
  logic signed [17:0] noise_value;

  // shadow copy of the block's state
  logic [7:0] perm_shadow [256];
  longint org_x, org_y, org_z, scl_x, scl_y, scl_z, amp;

  sample_t expected_samples[$];
  int n_fail = 0;
  int n_checked = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  simplex_noise_accumulate dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers and noise predictor
  // ---------------------------------------------------------------------------
  function automatic longint fmul(longint a, longint b);
    fmul = (a * b) >>> 16;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    clamp = v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint map_coord(logic signed [31:0] p, longint s, longint o);
    longint prod;
    prod = longint'(p) * s;
    map_coord = clamp((prod >>> 16) + o, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic int perm_at(longint idx);
    perm_at = perm_shadow[idx & 255];
  endfunction

  function automatic longint grad_dot(int g, longint dx, longint dy, longint dz);
    case (g)
      0: grad_dot = dx + dy;
      1: grad_dot = -dx + dy;
      2: grad_dot = dx - dy;
      3: grad_dot = -dx - dy;
      4: grad_dot = dx + dz;
      5: grad_dot = -dx + dz;
      6: grad_dot = dx - dz;
      7: grad_dot = -dx - dz;
      8: grad_dot = dy + dz;
      9: grad_dot = -dy + dz;
      10: grad_dot = dy - dz;
      default: grad_dot = -dy - dz;
    endcase
  endfunction

  function automatic longint corner_term(longint lim, longint dx, longint dy, longint dz,
                                         int h);
    longint t, t2, t4;
    t = lim - fmul(dx, dx) - fmul(dy, dy) - fmul(dz, dz);
    if (t < 0) return 0;
    t2 = fmul(t, t);
    t4 = fmul(t2, t2);
    return fmul(t4, grad_dot(h % 12, dx, dy, dz));
  endfunction

  function automatic longint simplex2(longint x, longint y);
    longint s, i, j, t, x0, y0, ax, ay, sum;
    s = fmul(x + y, SKEW2);
    i = (x + s) >>> 16;
    j = (y + s) >>> 16;
    t = (i + j) * UNSKEW2;
    x0 = x - i * ONE_Q + t;
    y0 = y - j * ONE_Q + t;
    ax = (x0 > y0) ? 1 : 0;
    ay = 1 - ax;
    sum = corner_term(FALL2, x0, y0, 0, perm_at(i + perm_at(j)));
    sum += corner_term(FALL2, x0 - ax * ONE_Q + UNSKEW2, y0 - ay * ONE_Q + UNSKEW2, 0,
                       perm_at(i + ax + perm_at(j + ay)));
    sum += corner_term(FALL2, x0 - ONE_Q + 2 * UNSKEW2, y0 - ONE_Q + 2 * UNSKEW2, 0,
                       perm_at(i + 1 + perm_at(j + 1)));
    return sum * 70;
  endfunction

  function automatic longint simplex3(longint x, longint y, longint z);
    longint s, i, j, k, t, x0, y0, z0, sum;
    longint a0, a1, a2, b0, b1, b2;
    s = fmul(x + y + z, SKEW3);
    i = (x + s) >>> 16;
    j = (y + s) >>> 16;
    k = (z + s) >>> 16;
    t = (i + j + k) * UNSKEW3;
    x0 = x - i * ONE_Q + t;
    y0 = y - j * ONE_Q + t;
    z0 = z - k * ONE_Q + t;
    // order the corners by the largest offset axis
    if (x0 >= y0) begin
      if (y0 >= z0) begin
        {a0, a1, a2, b0, b1, b2} = {64'd1, 64'd0, 64'd0, 64'd1, 64'd1, 64'd0};
      end else if (x0 >= z0) begin
        {a0, a1, a2, b0, b1, b2} = {64'd1, 64'd0, 64'd0, 64'd1, 64'd0, 64'd1};
      end else begin
        {a0, a1, a2, b0, b1, b2} = {64'd0, 64'd0, 64'd1, 64'd1, 64'd0, 64'd1};
      end
    end else begin
      if (y0 < z0) begin
        {a0, a1, a2, b0, b1, b2} = {64'd0, 64'd0, 64'd1, 64'd0, 64'd1, 64'd1};
      end else if (x0 < z0) begin
        {a0, a1, a2, b0, b1, b2} = {64'd0, 64'd1, 64'd0, 64'd0, 64'd1, 64'd1};
      end else begin
        {a0, a1, a2, b0, b1, b2} = {64'd0, 64'd1, 64'd0, 64'd1, 64'd1, 64'd0};
      end
    end
    sum = corner_term(FALL3, x0, y0, z0, perm_at(i + perm_at(j + perm_at(k))));
    sum += corner_term(FALL3, x0 - a0 * ONE_Q + UNSKEW3, y0 - a1 * ONE_Q + UNSKEW3,
                       z0 - a2 * ONE_Q + UNSKEW3,
                       perm_at(i + a0 + perm_at(j + a1 + perm_at(k + a2))));
    sum += corner_term(FALL3, x0 - b0 * ONE_Q + 2 * UNSKEW3, y0 - b1 * ONE_Q + 2 * UNSKEW3,
                       z0 - b2 * ONE_Q + 2 * UNSKEW3,
                       perm_at(i + b0 + perm_at(j + b1 + perm_at(k + b2))));
    sum += corner_term(FALL3, x0 - ONE_Q + 3 * UNSKEW3, y0 - ONE_Q + 3 * UNSKEW3,
                       z0 - ONE_Q + 3 * UNSKEW3,
                       perm_at(i + 1 + perm_at(j + 1 + perm_at(k + 1))));
    return sum * 32;
  endfunction

  // Apply one accepted word to the shadow state and queue its sample
  task automatic predict_word(logic [1:0] act, logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz, logic signed [31:0] acc,
                              logic [7:0] idx, logic [7:0] val);
    longint n, sum;
    sample_t smp;
    if (act == ACT_LOAD) begin
      perm_shadow[idx] = val;
      return;
    end
    if (act == ACT_NOISE2)
      n = simplex2(map_coord(px, scl_x, org_x), map_coord(py, scl_y, org_y));
    else if (act == ACT_NOISE3)
      n = simplex3(map_coord(px, scl_x, org_x), map_coord(py, scl_y, org_y),
                   map_coord(pz, scl_z, org_z));
    else
      return;
    n = clamp(n, -ONE_Q, ONE_Q);
    sum = longint'(acc) + ((n * amp) >>> 16);
    smp.acc = 32'(clamp(sum, -64'sd2147483648, 64'sd2147483647));
    smp.noise = 18'(n);
    expected_samples.push_back(smp);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] act, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz, logic signed [31:0] acc,
                           logic [7:0] idx, logic [7:0] val);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action <= act;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    acc_in <= acc;
    table_index <= idx;
    table_value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_word(act, px, py, pz, acc, idx, val);
    n_sent++;
  endtask

  // Wait for every queued sample, then let the pipe empty of loads
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_ORIGIN_X: org_x = v[23:0];
      REG_ORIGIN_Y: org_y = v[23:0];
      REG_ORIGIN_Z: org_z = v[23:0];
      REG_SCALE_X: scl_x = v;
      REG_SCALE_Y: scl_y = v;
      REG_SCALE_Z: scl_z = v;
      default: amp = v[23:0];
    endcase
  endtask

  task automatic write_all_regs(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz,
                                logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                logic [23:0] a);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    write_reg(REG_AMPLITUDE, a);
  endtask

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: rand_pos = $urandom;
      1: rand_pos = $signed($urandom_range(2097152)) - 1048576;
      2: rand_pos = $signed($urandom_range(33554432)) - 16777216;
      default: rand_pos = ($signed($urandom_range(64)) - 32) * 65536
                          + $signed($urandom_range(8)) - 4;
    endcase
  endfunction

  // Fill the whole table with a shuffled permutation so no read hits a hole
  task automatic test_table_load();
    int order [256];
    int k, tmp;
    for (int i = 0; i < 256; i++) order[i] = i;
    for (int i = 255; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < 256; i++)
      send_word(ACT_LOAD, $urandom, $urandom, $urandom, $urandom, 8'(i), 8'(order[i]));
  endtask

  task automatic test_directed();
    logic signed [31:0] maxv, minv;
    maxv = 32'sh7fffffff;
    minv = 32'sh80000000;
    send_word(ACT_NOISE2, 0, 0, 0, 0, 8'd0, 8'd0);
    send_word(ACT_NOISE3, 0, 0, 0, 0, 8'd255, 8'd255);
    send_word(ACT_NOISE2, maxv, maxv, maxv, maxv, 8'hff, 8'hff);
    send_word(ACT_NOISE2, minv, minv, minv, minv, 8'h00, 8'h00);
    send_word(ACT_NOISE3, maxv, minv, maxv, minv, 8'h55, 8'haa);
    send_word(ACT_NOISE3, minv, maxv, minv, maxv, 8'haa, 8'h55);
    send_word(ACT_NOISE2, 32'sh00008000, 32'sh00014000, 0, maxv, 8'd0, 8'd0);
    send_word(ACT_NOISE3, 32'sh00018000, 32'sh00004000, 32'sh00022000, minv, 8'd0, 8'd0);
    send_word(ACT_NOISE3, -32'sh00020000, 32'sh00030000, -32'sh00010000, 0, 8'd0, 8'd0);
    // unused action code gives no sample
    send_word(ACT_SPARE, 32'sh12345678, 0, 0, 0, 8'd0, 8'd0);
    // reload extremes of the table range with their own values
    send_word(ACT_LOAD, 0, 0, 0, 0, 8'd255, perm_shadow[255]);
    send_word(ACT_LOAD, 0, 0, 0, 0, 8'd0, perm_shadow[0]);
    // accumulator saturation with full amplitude
    write_all_regs(24'd0, 24'd0, 24'd0, 32'd65536, 32'd65536, 32'd65536, 24'hffffff);
    for (int i = 0; i < 6; i++) begin
      send_word(ACT_NOISE2, rand_pos(), rand_pos(), 0, maxv, 8'd0, 8'd0);
      send_word(ACT_NOISE3, rand_pos(), rand_pos(), rand_pos(), minv, 8'd0, 8'd0);
    end
  endtask

  // Mostly noise words, some table rewrites and dropped words
  task automatic test_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8)
        send_word(ACT_LOAD, $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                  8'($urandom));
      else if (pick < 12)
        send_word(ACT_SPARE, $urandom, $urandom, $urandom, $urandom, 8'($urandom),
                  8'($urandom));
      else
        send_word(pick < 56 ? ACT_NOISE2 : ACT_NOISE3, rand_pos(), rand_pos(), rand_pos(),
                  $urandom, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_all_regs(24'd0, 24'd0, 24'd0, 32'd65536, 32'd65536, 32'd65536, 24'd65536);
    test_random(count);
    write_all_regs(24'hffffff, 24'hffffff, 24'hffffff, 32'hffffffff, 32'hffffffff,
                   32'hffffffff, 24'hffffff);
    test_random(count / 4);
    write_all_regs(24'($urandom), 24'($urandom), 24'($urandom), 32'd0, 32'd0, 32'd0, 24'd0);
    test_random(count / 8);
    write_all_regs(24'($urandom), 24'($urandom), 24'($urandom), $urandom_range(262144),
                   $urandom_range(262144), $urandom_range(262144), 24'($urandom));
    test_random(count / 2);
  endtask

  // ---------------------------------------------------------------------------
  // Output checker, receiver stalls and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected output word acc_out=%0d noise_value=%0d", acc_out, noise_value);
          n_fail++;
        end else begin
          want = expected_samples.pop_front();
          n_checked++;
          if (acc_out !== want.acc) begin
            $error("acc_out: expected %0d, got %0d", want.acc, acc_out);
            n_fail++;
          end
          if (noise_value !== want.noise) begin
            $error("noise_value: expected %0d, got %0d", want.noise, noise_value);
            n_fail++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    org_x = 0;
    org_y = 0;
    org_z = 0;
    scl_x = 65536;
    scl_y = 65536;
    scl_z = 65536;
    amp = 65536;
    for (int i = 0; i < 256; i++) perm_shadow[i] = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_phase(0, 0, 110);
    test_phase(74, 0, 110);
    test_phase(0, 74, 110);
    test_phase(16, 16, 110);
    drain();
    $display("Covered %0d accepted words, %0d output samples checked,", n_sent, n_checked);
    $display("across table loads, 2D/3D noise, dropped words and four register settings.");
    if (n_fail == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/snx_pkg.sv
rtl/snx_perm_ram.sv
rtl/simplex_noise_accumulate.sv
test/testbench.sv
